// File: src/vqdm_pkg.sv
// Package for the virtqueue descriptor manager: channel payload structs,
// descriptor entry layout, command and result codes, descriptor constants.
// No dependencies.
`default_nettype none

package vqdm_pkg;

   localparam int QUEUE_SIZE_DEF = 256;

   localparam logic [15:0] LINK_END     = 16'hFFFF;
   localparam logic [1:0]  FLAG_NEXT    = 2'b01;
   localparam logic [1:0]  FLAG_WRITE   = 2'b10;
   localparam logic [31:0] HDR_BYTES    = 32'd16;
   localparam logic [31:0] STATUS_BYTES = 32'd1;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_RETIRE = 1'b1;

   typedef enum logic [1:0] {
      RC_SUBMITTED = 2'd0,
      RC_REJECTED  = 2'd1,
      RC_RETIRED   = 2'd2
   } result_code_type;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  req_type;
      logic [63:0] hdr_addr;
      logic [63:0] data_addr;
      logic [31:0] data_len;
      logic [63:0] status_addr;
      logic [7:0]  used_id;
   } req_type;

   typedef struct packed {
      result_code_type result_code;
      logic [7:0]      head_index;
      logic [7:0]      avail_slot;
      logic [8:0]      free_count;
      logic [8:0]      freed;
   } rsp_type;

   typedef struct packed {
      logic [63:0] address;
      logic [31:0] length;
      logic [1:0]  flags;
   } desc_entry_type;

endpackage

`default_nettype wire

// File: src/virtqueue_descriptor_manager_top.sv
// Virtqueue descriptor manager, driver side of a split virtqueue.
// After reset the block writes the descending free list into the link memory,
// with req_stall high, before it takes a transfer. A submit pops three
// descriptors one per cycle, each waiting on the registered read of the
// single-port link memory. A rejected submit pops nothing and is decided in
// the transfer cycle. A retire goes through a read state and a write state
// per link (read, then write back onto the free list); a walk cut off by the
// cap or by an out-of-range id ends in one more read state.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
// Depends on vqdm_pkg, vqdm_ctrl, vqdm_link_ram, vqdm_desc_ram.
`default_nettype none

module virtqueue_descriptor_manager_top
   import vqdm_pkg::*;
#(
   parameter int QUEUE_SIZE = QUEUE_SIZE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IW = $clog2(QUEUE_SIZE);

   logic           link_we;
   logic           link_re;
   logic [IW-1:0]  link_addr;
   logic [15:0]    link_wdata;
   logic [15:0]    link_rdata;
   logic           desc_we;
   logic           desc_re;
   logic [IW-1:0]  desc_addr;
   desc_entry_type desc_wdata;
   desc_entry_type desc_rdata;

   vqdm_ctrl #(
      .QUEUE_SIZE (QUEUE_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .link_we    (link_we),
      .link_re    (link_re),
      .link_addr  (link_addr),
      .link_wdata (link_wdata),
      .link_rdata (link_rdata),
      .desc_we    (desc_we),
      .desc_re    (desc_re),
      .desc_addr  (desc_addr),
      .desc_wdata (desc_wdata),
      .desc_rdata (desc_rdata)
   );

   vqdm_link_ram #(
      .QUEUE_SIZE (QUEUE_SIZE)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .re    (link_re),
      .addr  (link_addr),
      .wdata (link_wdata),
      .rdata (link_rdata)
   );

   vqdm_desc_ram #(
      .QUEUE_SIZE (QUEUE_SIZE)
   ) u_desc_ram (
      .clock (clock),
      .we    (desc_we),
      .re    (desc_re),
      .addr  (desc_addr),
      .wdata (desc_wdata),
      .rdata (desc_rdata)
   );

endmodule

`default_nettype wire

// File: src/vqdm_link_ram.sv
// Link memory of the descriptor table: one port, registered read.
// Depends on vqdm_pkg.
`default_nettype none

module vqdm_link_ram
   import vqdm_pkg::*;
#(
   parameter int QUEUE_SIZE = QUEUE_SIZE_DEF,
   localparam int IW = $clog2(QUEUE_SIZE)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic          re,
   input  wire logic [IW-1:0] addr,
   input  wire logic [15:0]   wdata,
   output logic      [15:0]   rdata
);

   logic [15:0] mem [QUEUE_SIZE];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/vqdm_desc_ram.sv
// Descriptor memory: address, length and flag bits per entry, one port,
// registered read. Depends on vqdm_pkg.
`default_nettype none

module vqdm_desc_ram
   import vqdm_pkg::*;
#(
   parameter int QUEUE_SIZE = QUEUE_SIZE_DEF,
   localparam int IW = $clog2(QUEUE_SIZE)
) (
   input  wire logic           clock,
   input  wire logic           we,
   input  wire logic           re,
   input  wire logic [IW-1:0]  addr,
   input  wire desc_entry_type wdata,
   output desc_entry_type      rdata
);

   desc_entry_type mem [QUEUE_SIZE];
   desc_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/vqdm_ctrl.sv
// Sequencer: sets up the free list after reset, pops three descriptors per
// submit, walks and frees chains on retire, keeps free list head, counters and
// the result register. Depends on vqdm_pkg; drives vqdm_link_ram and vqdm_desc_ram.
`default_nettype none

module vqdm_ctrl
   import vqdm_pkg::*;
#(
   parameter int QUEUE_SIZE = QUEUE_SIZE_DEF,
   localparam int IW = $clog2(QUEUE_SIZE),
   localparam int CW = $clog2(QUEUE_SIZE + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire req_type        req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output rsp_type             rsp_data,
   output logic                link_we,
   output logic                link_re,
   output logic [IW-1:0]       link_addr,
   output logic [15:0]         link_wdata,
   input  wire logic [15:0]    link_rdata,
   output logic                desc_we,
   output logic                desc_re,
   output logic [IW-1:0]       desc_addr,
   output desc_entry_type      desc_wdata,
   input  wire desc_entry_type desc_rdata
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP1,
      ST_POP2,
      ST_POP_END,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_HOLD
   } state_type;

   localparam logic [15:0]   QSIZE16   = 16'(QUEUE_SIZE);
   localparam logic [CW-1:0] QSIZE_CW  = CW'(QUEUE_SIZE);
   localparam logic [15:0]   SLOT_MASK = 16'(QUEUE_SIZE - 1);
   localparam logic [15:0]   HEAD_INIT = 16'(QUEUE_SIZE - 1);
   localparam logic [CW-1:0] MIN_FREE  = CW'(3);
   localparam logic [IW-1:0] INIT_LAST = IW'(QUEUE_SIZE - 1);

   state_type      state_ff, state_in;
   logic [IW-1:0]  init_ff, init_in;
   logic [15:0]    free_head_ff, free_head_in;
   logic [CW-1:0]  free_total_ff, free_total_in;
   logic [15:0]    avail_ff, avail_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   rsp_type        pend_rsp_ff, pend_rsp_in;
   logic [15:0]    cur_ff, cur_in;
   logic [CW-1:0]  steps_ff, steps_in;
   logic [7:0]     head_ff, head_in;
   logic [IW-1:0]  pend_idx_ff, pend_idx_in;
   logic           pend_oob_ff, pend_oob_in;
   logic [63:0]    data_addr_ff, data_addr_in;
   logic [31:0]    data_len_ff, data_len_in;
   logic [1:0]     data_flags_ff, data_flags_in;
   logic [63:0]    status_addr_ff, status_addr_in;

   logic           out_free;
   logic [15:0]    link_val;
   logic           pop_en;
   logic [15:0]    pop_cur;
   logic           pop_oob;
   logic           fin_en;
   rsp_type        fin_rsp;
   logic           walk_ok;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign link_val  = pend_oob_ff ? LINK_END : link_rdata;

   assign walk_ok = (cur_ff < QSIZE16) && (steps_ff < QSIZE_CW)
                    && (free_total_ff < QSIZE_CW);

   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      free_head_in   = free_head_ff;
      free_total_in  = free_total_ff;
      avail_in       = avail_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      pend_rsp_in    = pend_rsp_ff;
      cur_in         = cur_ff;
      steps_in       = steps_ff;
      head_in        = head_ff;
      pend_idx_in    = pend_idx_ff;
      pend_oob_in    = pend_oob_ff;
      data_addr_in   = data_addr_ff;
      data_len_in    = data_len_ff;
      data_flags_in  = data_flags_ff;
      status_addr_in = status_addr_ff;

      link_we    = 1'b0;
      link_re    = 1'b0;
      link_addr  = '0;
      link_wdata = free_head_ff;
      desc_we    = 1'b0;
      desc_re    = 1'b0;
      desc_addr  = '0;
      desc_wdata = '{address: req_data.hdr_addr, length: HDR_BYTES, flags: FLAG_NEXT};

      pop_en  = 1'b0;
      pop_cur = free_head_ff;
      pop_oob = 1'b0;
      fin_en  = 1'b0;
      fin_rsp = '{result_code: RC_SUBMITTED, head_index: 8'd0, avail_slot: 8'd0,
                  free_count: 9'd0, freed: 9'd0};

      unique case (state_ff)
         ST_INIT: begin
            link_we    = 1'b1;
            link_addr  = init_ff;
            link_wdata = (init_ff == '0) ? LINK_END : 16'(init_ff) - 16'd1;
            if (init_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff - IW'(1);
            end
         end
         ST_IDLE: begin
            data_addr_in   = req_data.data_addr;
            data_len_in    = req_data.data_len;
            data_flags_in  = (req_data.req_type == 3'd0) ? (FLAG_WRITE | FLAG_NEXT)
                                                         : FLAG_NEXT;
            status_addr_in = req_data.status_addr;
            if (req_valid) begin
               if (req_data.cmd == CMD_SUBMIT) begin
                  if (free_total_ff < MIN_FREE) begin
                     fin_en                 = 1'b1;
                     fin_rsp.result_code    = RC_REJECTED;
                     fin_rsp.free_count     = 9'(free_total_ff);
                  end else begin
                     pop_en   = 1'b1;
                     pop_cur  = free_head_ff;
                     head_in  = 8'(free_head_ff);
                     state_in = ST_POP1;
                  end
               end else begin
                  cur_in   = 16'(req_data.used_id);
                  head_in  = req_data.used_id;
                  steps_in = '0;
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_POP1: begin
            pop_en     = 1'b1;
            pop_cur    = link_val;
            desc_wdata = '{address: data_addr_ff, length: data_len_ff, flags: data_flags_ff};
            state_in   = ST_POP2;
         end
         ST_POP2: begin
            pop_en     = 1'b1;
            pop_cur    = link_val;
            desc_wdata = '{address: status_addr_ff, length: STATUS_BYTES, flags: FLAG_WRITE};
            state_in   = ST_POP_END;
         end
         ST_POP_END: begin
            free_head_in       = link_val;
            free_total_in      = free_total_ff - MIN_FREE;
            avail_in           = avail_ff + 16'd1;
            fin_en             = 1'b1;
            fin_rsp.result_code = RC_SUBMITTED;
            fin_rsp.head_index = head_ff;
            fin_rsp.avail_slot = 8'(avail_ff & SLOT_MASK);
            fin_rsp.free_count = 9'(free_total_in);
         end
         ST_WALK_RD: begin
            if (walk_ok) begin
               link_re       = 1'b1;
               link_addr     = cur_ff[IW-1:0];
               desc_re       = 1'b1;
               desc_addr     = cur_ff[IW-1:0];
               pend_idx_in   = cur_ff[IW-1:0];
               pend_oob_in   = 1'b0;
               state_in      = ST_WALK_WR;
            end else begin
               fin_en              = 1'b1;
               fin_rsp.result_code = RC_RETIRED;
               fin_rsp.head_index  = head_ff;
               fin_rsp.free_count  = 9'(free_total_ff);
               fin_rsp.freed       = 9'(steps_ff);
            end
         end
         ST_WALK_WR: begin
            link_we       = 1'b1;
            link_addr     = pend_idx_ff;
            link_wdata    = free_head_ff;
            free_head_in  = 16'(pend_idx_ff);
            free_total_in = free_total_ff + CW'(1);
            steps_in      = steps_ff + CW'(1);
            if ((desc_rdata.flags & FLAG_NEXT) != 2'b00) begin
               cur_in   = link_val;
               state_in = ST_WALK_RD;
            end else begin
               fin_en              = 1'b1;
               fin_rsp.result_code = RC_RETIRED;
               fin_rsp.head_index  = head_ff;
               fin_rsp.free_count  = 9'(free_total_in);
               fin_rsp.freed       = 9'(steps_in);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_rsp_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pop_oob = (pop_cur >= QSIZE16);
      if (pop_en) begin
         pend_idx_in   = pop_cur[IW-1:0];
         pend_oob_in   = pop_oob;
         if (!pop_oob) begin
            link_re   = 1'b1;
            link_addr = pop_cur[IW-1:0];
            desc_we   = 1'b1;
            desc_addr = pop_cur[IW-1:0];
         end
      end

      if (fin_en) begin
         if (out_free) begin
            rsp_in       = fin_rsp;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_rsp_in = fin_rsp;
            state_in    = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_ff       <= INIT_LAST;
         free_head_ff  <= HEAD_INIT;
         free_total_ff <= QSIZE_CW;
         avail_ff      <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         free_head_ff  <= free_head_in;
         free_total_ff <= free_total_in;
         avail_ff      <= avail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff         <= rsp_in;
      pend_rsp_ff    <= pend_rsp_in;
      cur_ff         <= cur_in;
      steps_ff       <= steps_in;
      head_ff        <= head_in;
      pend_idx_ff    <= pend_idx_in;
      pend_oob_ff    <= pend_oob_in;
      data_addr_ff   <= data_addr_in;
      data_len_ff    <= data_len_in;
      data_flags_ff  <= data_flags_in;
      status_addr_ff <= status_addr_in;
   end

endmodule

`default_nettype wire

// File: src/vqdm_checker.sv
// Port-level checks on the result channel of the descriptor manager, and the
// bind that attaches them to the top level. Depends on vqdm_pkg.
`default_nettype none

module vqdm_checker
   import vqdm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_code == RC_REJECTED) |->
         (rsp_data.head_index == 8'd0) && (rsp_data.avail_slot == 8'd0)
         && (rsp_data.freed == 9'd0))
      else $error("rejected submit carries nonzero fields");

   a_submit_frees_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_code == RC_SUBMITTED) |-> rsp_data.freed == 9'd0)
      else $error("submit reports freed descriptors");

   a_retire_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_code == RC_RETIRED) |-> rsp_data.avail_slot == 8'd0)
      else $error("retire reports an available slot");

endmodule

bind virtqueue_descriptor_manager_top vqdm_checker u_vqdm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: tb/sv/vqdm_chain_checker.sv
// Checker for the virtqueue descriptor manager: watches both channels, predicts each
// result from its own copy of the descriptor table and free list, and compares.
// Depends on vqdm_pkg.
module vqdm_chain_checker
   import vqdm_pkg::*;
#(
   parameter int QS = QUEUE_SIZE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output logic [QS-1:0] retire_ok,
   output int           outstanding,
   output int           error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] link_mem [QS];
   logic [1:0]  flag_mem [QS];
   bit          written [QS];
   logic [15:0] free_head;
   int unsigned free_total;
   logic [15:0] avail_ctr;

   int unsigned walk_tag;
   int unsigned tag_mem [QS];
   logic [15:0] relink [QS];

   rsp_type outcome_fifo [$];
   rsp_type want;

   task automatic clear_ring();
      for (int i = 0; i < QS; i++) begin
         link_mem[i] = (i == 0) ? LINK_END : 16'(i - 1);
         flag_mem[i] = 2'b00;
         written[i]  = 1'b0;
         tag_mem[i]  = 0;
      end
      free_head  = 16'(QS - 1);
      free_total = QS;
      avail_ctr  = 16'd0;
      walk_tag   = 0;
   endtask

   function automatic logic [15:0] pop_desc(input logic [15:0] idx, input logic [1:0] fl);
      logic [15:0] nxt;
      if (idx >= QS) return LINK_END;
      nxt = link_mem[idx];
      flag_mem[idx] = fl;
      written[idx] = 1'b1;
      return nxt;
   endfunction

   function automatic rsp_type desc_ring_step(input req_type item);
      rsp_type     r;
      logic [15:0] cur;
      logic [1:0]  dfl;
      int unsigned id;
      int unsigned steps;
      int unsigned cnt;
      r = '0;
      if (item.cmd == CMD_SUBMIT) begin
         if (free_total < 3) begin
            r.result_code = RC_REJECTED;
         end else begin
            dfl = (item.req_type == 3'd0) ? (FLAG_WRITE | FLAG_NEXT) : FLAG_NEXT;
            cur = free_head;
            r.head_index = cur[7:0];
            cur = pop_desc(cur, FLAG_NEXT);
            cur = pop_desc(cur, dfl);
            cur = pop_desc(cur, FLAG_WRITE);
            free_head = cur;
            free_total -= 3;
            r.avail_slot = 8'(avail_ctr & 16'(QS - 1));
            avail_ctr = avail_ctr + 16'd1;
            r.result_code = RC_SUBMITTED;
         end
      end else begin
         r.result_code = RC_RETIRED;
         r.head_index = item.used_id;
         id = item.used_id;
         steps = 0;
         cnt = 0;
         while (id < QS && steps < QS && free_total < QS) begin
            cur = id[15:0];
            id = link_mem[cur];
            link_mem[cur] = free_head;
            free_head = cur;
            free_total++;
            cnt++;
            steps++;
            if ((flag_mem[cur] & FLAG_NEXT) == 2'b00) break;
         end
         r.freed = cnt[8:0];
      end
      r.free_count = free_total[8:0];
      return r;
   endfunction

   // dry-run the walk from start; fail if it would read flags never written
   function automatic bit walk_reads_written(input int unsigned start);
      int unsigned cur;
      int unsigned f;
      int unsigned steps;
      logic [15:0] hd;
      logic [15:0] nxt;
      walk_tag++;
      cur = start;
      f = free_total;
      hd = free_head;
      steps = 0;
      while (cur < QS && steps < QS && f < QS) begin
         if (!written[cur]) return 1'b0;
         nxt = (tag_mem[cur] == walk_tag) ? relink[cur] : link_mem[cur];
         tag_mem[cur] = walk_tag;
         relink[cur] = hd;
         hd = cur[15:0];
         f++;
         steps++;
         if ((flag_mem[cur] & FLAG_NEXT) == 2'b00) break;
         cur = nxt;
      end
      return 1'b1;
   endfunction

   function automatic logic [QS-1:0] retire_safety();
      logic [QS-1:0] m;
      for (int i = 0; i < QS; i++) m[i] = walk_reads_written(i);
      return m;
   endfunction

   task automatic check_field(input string fname, input logic [8:0] exp_v,
                              input logic [8:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, actual %0d", fname, exp_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_ring();
         outcome_fifo.delete();
         error_count = 0;
         retire_ok <= retire_safety();
         outstanding <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            outcome_fifo.push_back(desc_ring_step(req_data));
            retire_ok <= retire_safety();
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcome_fifo.size() == 0) begin
               $error("result with nothing pending: code %0d head %0d",
                      rsp_data.result_code, rsp_data.head_index);
               error_count++;
            end else begin
               want = outcome_fifo.pop_front();
               check_field("result_code", want.result_code, rsp_data.result_code);
               check_field("head_index", want.head_index, rsp_data.head_index);
               check_field("avail_slot", want.avail_slot, rsp_data.avail_slot);
               check_field("free_count", want.free_count, rsp_data.free_count);
               check_field("freed", want.freed, rsp_data.freed);
            end
         end
         outstanding <= outcome_fifo.size();
      end
   end

endmodule

// File: tb/sv/tb_top.sv
// Top of the descriptor manager testbench: clock, reset, submit and retire stimulus
// with random gaps and result-side stalls, and the final verdict.
// Depends on vqdm_pkg, virtqueue_descriptor_manager_top, vqdm_chain_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vqdm_pkg::*;

   localparam int    QS           = QUEUE_SIZE_DEF;
   localparam int    ITEM_TARGET  = 1000;
   localparam int    END_WAIT     = 600;
   localparam longint RUN_LIMIT_NS = 60_000_000;

   typedef enum int {
      PICK_FIXED,
      PICK_LIVE,
      PICK_MID,
      PICK_ANY
   } pick_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [QS-1:0] retire_ok;
   int            outstanding;
   int            error_count;

   logic [7:0] live_heads [$];
   int         quiet_left = 0;
   int         hold_cnt   = 0;
   int         run_cnt    = 0;
   int         stall_len;

   virtqueue_descriptor_manager_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vqdm_chain_checker #(.QS(QS)) u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .retire_ok   (retire_ok),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int run_span();
      if ($urandom_range(15, 0) == 0) return $urandom_range(150, 40);
      return $urandom_range(10, 1);
   endfunction

   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (run_cnt != 0) begin
         rsp_stall <= 1'b0;
         run_cnt <= run_cnt - 1;
      end else begin
         stall_len = idle_len();
         rsp_stall <= (stall_len != 0);
         hold_cnt <= stall_len;
         run_cnt <= run_span();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_data.result_code == RC_SUBMITTED) begin
         live_heads.push_back(rsp_data.head_index);
      end
   end

   function automatic req_type random_request(input logic cmd);
      req_type r;
      r.cmd = cmd;
      r.req_type = ($urandom_range(3, 0) == 0) ? 3'd0 : 3'($urandom_range(7, 0));
      r.hdr_addr = {$urandom, $urandom};
      r.data_addr = {$urandom, $urandom};
      case ($urandom_range(9, 0))
         0: begin
            r.data_len = '0;
         end
         1: begin
            r.data_len = '1;
         end
         default: begin
            r.data_len = $urandom;
         end
      endcase
      r.status_addr = {$urandom, $urandom};
      r.used_id = 8'($urandom_range(255, 0));
      return r;
   endfunction

   function automatic bit pick_retire_id(input pick_mode_type how, input logic [7:0] fixed_id,
                                         output logic [7:0] id);
      int         k;
      logic [7:0] cand;
      id = fixed_id;
      k = 0;
      for (int t = 0; t < 16; t++) begin
         case (how)
            PICK_FIXED: begin
               cand = fixed_id;
            end
            PICK_LIVE, PICK_MID: begin
               if (live_heads.size() == 0) return 1'b0;
               k = $urandom_range(live_heads.size() - 1, 0);
               cand = live_heads[k];
               if (how == PICK_MID) cand = cand - 8'd1;
            end
            default: begin
               cand = 8'($urandom_range(QS - 1, 0));
            end
         endcase
         if (retire_ok[cand]) begin
            if (how == PICK_LIVE) live_heads.delete(k);
            id = cand;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // retires always get an idle gap so the checker's walk-safety map covers the last transfer
   task automatic send_item(input req_type proto, input pick_mode_type how);
      int         gap;
      req_type    item;
      logic [7:0] id;
      gap = (quiet_left > 0) ? 0 : idle_len();
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(40, 0) == 0) quiet_left = $urandom_range(60, 15);
      if (proto.cmd == CMD_RETIRE && gap == 0) gap = 1;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item = proto;
      if (item.cmd == CMD_RETIRE) begin
         if (pick_retire_id(how, proto.used_id, id)) item.used_id = id;
         else item.cmd = CMD_SUBMIT;
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      req_type proto;
      int      sent;
      int      burst_len;
      int      p_submit;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      proto = random_request(CMD_RETIRE);
      proto.used_id = 8'd0;
      send_item(proto, PICK_FIXED);
      proto.used_id = 8'hFF;
      send_item(proto, PICK_FIXED);

      proto = random_request(CMD_SUBMIT);
      proto.req_type = 3'd0;
      proto.hdr_addr = '0;
      proto.data_addr = '0;
      proto.data_len = '0;
      proto.status_addr = '0;
      proto.used_id = '0;
      send_item(proto, PICK_FIXED);
      proto.req_type = 3'd7;
      proto.hdr_addr = '1;
      proto.data_addr = '1;
      proto.data_len = '1;
      proto.status_addr = '1;
      proto.used_id = '1;
      send_item(proto, PICK_FIXED);
      for (int t = 1; t < 7; t++) begin
         proto = random_request(CMD_SUBMIT);
         proto.req_type = 3'(t);
         send_item(proto, PICK_FIXED);
      end
      settle();

      repeat (4) send_item(random_request(CMD_RETIRE), PICK_LIVE);
      send_item(random_request(CMD_RETIRE), PICK_MID);
      send_item(random_request(CMD_RETIRE), PICK_ANY);
      send_item(random_request(CMD_SUBMIT), PICK_FIXED);
      send_item(random_request(CMD_SUBMIT), PICK_FIXED);
      settle();

      sent = 0;
      while (sent < ITEM_TARGET) begin
         burst_len = $urandom_range(80, 20);
         case ($urandom_range(2, 0))
            0: begin
               p_submit = 85;
            end
            1: begin
               p_submit = 50;
            end
            default: begin
               p_submit = 20;
            end
         endcase
         repeat (burst_len) begin
            if ($urandom_range(99, 0) < p_submit) begin
               send_item(random_request(CMD_SUBMIT), PICK_FIXED);
            end else if ($urandom_range(9, 0) != 0) begin
               send_item(random_request(CMD_RETIRE), PICK_LIVE);
            end else if ($urandom_range(1, 0) != 0) begin
               send_item(random_request(CMD_RETIRE), PICK_MID);
            end else begin
               send_item(random_request(CMD_RETIRE), PICK_ANY);
            end
            sent++;
         end
      end

      settle();
      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: sim.f
src/vqdm_pkg.sv
src/vqdm_link_ram.sv
src/vqdm_desc_ram.sv
src/vqdm_ctrl.sv
src/virtqueue_descriptor_manager_top.sv
src/vqdm_checker.sv
tb/sv/vqdm_chain_checker.sv
tb/sv/tb_top.sv
